FILE: hdl/fcs_pkg.sv
// ---------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the floppy command sequencer
// Job codes passed from the front part to the emitter, plus result codes.
// ---------------------------------------------------------------------------
`default_nettype none
package fcs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_DONE  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RETRY   = 3'd1,
    ST_WPROT   = 3'd2,
    ST_BADDMA  = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_IRQ    = 4'd1,
    PH_RST_SENSE  = 4'd2,
    PH_CAL_IRQ    = 4'd3,
    PH_CAL_SENSE  = 4'd4,
    PH_SEEK_IRQ   = 4'd5,
    PH_SEEK_SENSE = 4'd6,
    PH_XFER_IRQ   = 4'd7,
    PH_XFER_RES   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    MOTOR_OFF  = 2'd0,
    MOTOR_ON   = 2'd1,
    MOTOR_WAIT = 2'd2
  } motor_t;

  localparam logic [2:0] KIND_RESET = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_IRQ   = 3'd3;
  localparam logic [2:0] KIND_BYTE  = 3'd4;
  localparam logic [2:0] KIND_TICK  = 3'd5;

  localparam logic [9:0] PORT_DOR  = 10'h3f2;
  localparam logic [9:0] PORT_FIFO = 10'h3f5;
  localparam logic [9:0] PORT_CCR  = 10'h3f7;
  localparam logic [15:0] XFER_LAST = 16'h47ff;

  // one job: a flagged list of up to 11 result groups, rendered by the emitter
  typedef struct packed {
    logic       busy;      // single done, refused busy
    logic       dor_rst;   // DOR 0x00, DOR 0x0c
    logic       sense;     // sense interrupt + 2 fifo reads
    logic       xres;      // 7 fifo reads
    logic       ccr_spec;  // CCR 0, specify 3 bytes
    logic       motor_on;  // DOR 0x1c
    logic       recal;     // recalibrate 2 bytes
    logic       seek;      // seek 3 bytes
    logic       xfer;      // dma program + transfer command
    logic       dor_off;   // DOR 0x0c on motor stop
    logic       done;      // done result
    logic [2:0] status;
    logic       head;
    logic [7:0] cyl;
    logic       wr_op;
    logic [23:0] addr;
    logic [7:0] spec_t;
    logic [7:0] spec_l;
    logic [7:0] eot;
    logic [7:0] gap;
  } job_t;

  localparam int JOB_W = $bits(job_t);
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

endpackage
`default_nettype wire

FILE: hdl/floppy_command_sequencer.sv
// ---------------------------------------------------------------------------
// floppy_command_sequencer: host command sequencer for a 765-style FDC
// Front decodes events into jobs, a 4-entry queue decouples, back emits.
// ---------------------------------------------------------------------------
//  channel   dir  tuser / tdata / tlast
//  s_axis    in   tuser[2:0] kind; tdata[7:0] cylinder, [15:8] reply_byte
//  m_axis    out  tuser[1:0] action; tdata[9:0] port, [17:10] value, [20:18] status; tlast
//  apb       in   eight registers at 4*i
//
//  an event is accepted whenever the queue has room
//  a job is written into the queue RAM and reaches the head through its registered read
//  the emitter steps to a job's first result, then emits one per cycle unless the output stalls
//  a job carries from 0 to 20 results, a busy refusal a single one
//  ready drops only on a full queue; rst is synchronous; RAM and output data are not reset
`default_nettype none
module floppy_command_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // cylinder, reply_byte
  input  wire logic [2:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // port, value, status
  output logic [1:0]       m_axis_tuser,  // action
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] dma_address;
  logic [7:0]  specify_timing, specify_load, gap_length, sectors_per_track;
  logic [4:0]  transfer_retries, seek_retries;
  logic [3:0]  motor_idle_ticks;
  logic        push, pop, q_full;
  fcs_pkg::job_t job_in, job_out;
  logic [fcs_pkg::QAW-1:0] wp, rp;
  logic [fcs_pkg::QAW:0]   cnt;
  logic [fcs_pkg::JOB_W-1:0] rdata;
  logic        head_valid;
  logic [9:0]  port;
  logic [7:0]  value;
  logic [2:0]  status;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_address <= '0;
      specify_timing <= 8'd223;
      specify_load <= 8'd2;
      gap_length <= 8'd27;
      sectors_per_track <= 8'd18;
      transfer_retries <= 5'd20;
      seek_retries <= 5'd10;
      motor_idle_ticks <= 4'd6;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        3'd0: dma_address <= pwdata;
        3'd1: specify_timing <= pwdata[7:0];
        3'd2: specify_load <= pwdata[7:0];
        3'd3: gap_length <= pwdata[7:0];
        3'd4: sectors_per_track <= pwdata[7:0];
        3'd5: transfer_retries <= pwdata[4:0];
        3'd6: seek_retries <= pwdata[4:0];
        3'd7: motor_idle_ticks <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      3'd0: prdata = dma_address;
      3'd1: prdata = {24'd0, specify_timing};
      3'd2: prdata = {24'd0, specify_load};
      3'd3: prdata = {24'd0, gap_length};
      3'd4: prdata = {24'd0, sectors_per_track};
      3'd5: prdata = {27'd0, transfer_retries};
      3'd6: prdata = {27'd0, seek_retries};
      3'd7: prdata = {28'd0, motor_idle_ticks};
      default: prdata = '0;
    endcase
  end

  fcs_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser), .cylinder(s_axis_tdata[7:0]),
    .reply_byte(s_axis_tdata[15:8]),
    .dma_address, .specify_timing, .specify_load, .gap_length,
    .sectors_per_track, .transfer_retries, .seek_retries, .motor_idle_ticks,
    .q_full, .push, .job(job_in)
  );

  // job queue; head is read through the RAM's registered read port
  fcs_ram #(.Width(fcs_pkg::JOB_W), .Depth(fcs_pkg::QDEPTH)) u_q (
    .clk, .we(push), .waddr(wp), .wdata(job_in),
    .raddr(pop ? rp + 1'b1 : rp), .rdata
  );
  assign job_out = fcs_pkg::job_t'(rdata);
  assign q_full = (cnt == (fcs_pkg::QAW+1)'(fcs_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      head_valid <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (fcs_pkg::QAW+1)'(push) - (fcs_pkg::QAW+1)'(pop);
      // head data is valid once the registered read has seen a stored entry
      head_valid <= (cnt - (fcs_pkg::QAW+1)'(pop)) != '0 &&
                    !(pop && cnt == (fcs_pkg::QAW+1)'(1)) &&
                    !(!head_valid && cnt == '0);
    end
  end

  fcs_back u_back (
    .clk, .rst, .job_valid(head_valid), .job_take(pop), .job(job_out),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .action(m_axis_tuser), .port, .value, .status, .last(m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, status, value, port};
endmodule
`default_nettype wire

FILE: hdl/fcs_ram.sv
// ---------------------------------------------------------------------------
// fcs_ram: generic single-port-write, one-read RAM with registered read
// Used as the job queue storage between front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none
module fcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/fcs_front.sv
// ---------------------------------------------------------------------------
// fcs_front: sequencing state and classification of input events
// Updates phase, retry and motor state for each event and pushes one job.
// ---------------------------------------------------------------------------
`default_nettype none
module fcs_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   kind,
  input  wire logic [7:0]   cylinder,
  input  wire logic [7:0]   reply_byte,
  input  wire logic [31:0]  dma_address,
  input  wire logic [7:0]   specify_timing,
  input  wire logic [7:0]   specify_load,
  input  wire logic [7:0]   gap_length,
  input  wire logic [7:0]   sectors_per_track,
  input  wire logic [4:0]   transfer_retries,
  input  wire logic [4:0]   seek_retries,
  input  wire logic [3:0]   motor_idle_ticks,
  input  wire logic         q_full,
  output logic              push,
  output fcs_pkg::job_t     job
);
  fcs_pkg::phase_t phase, phase_next;
  fcs_pkg::motor_t motor_mode, motor_mode_next;
  logic       wr_op, wr_op_next;
  logic [4:0] attempt_count, attempt_count_next;
  logic [7:0] target_cylinder, target_cylinder_next;
  logic       seek_head, seek_head_next;
  logic [2:0] reply_index, reply_index_next;
  logic [7:0] status_zero, status_zero_next;
  logic [7:0] status_one, status_one_next;
  logic [7:0] status_two, status_two_next;
  logic [3:0] idle_countdown, idle_countdown_next;
  logic [4:0] bumped;
  logic       dma_bad, err;
  logic [16:0] end_addr;

  assign in_ready = !q_full;
  assign bumped = attempt_count + 5'd1;
  assign end_addr = {1'b0, dma_address[15:0]} + {1'b0, fcs_pkg::XFER_LAST};
  assign dma_bad = (dma_address[31:24] != 8'd0) || end_addr[16];
  assign err = ((status_zero & 8'hc8) != 8'd0) || ((status_one & 8'hb5) != 8'd0) ||
               ((status_two & 8'h77) != 8'd0) || (reply_byte != 8'd2);

  // event decode: next state and the job describing the results
  always_comb begin
    phase_next = phase;
    motor_mode_next = motor_mode;
    wr_op_next = wr_op;
    attempt_count_next = attempt_count;
    target_cylinder_next = target_cylinder;
    seek_head_next = seek_head;
    reply_index_next = reply_index;
    status_zero_next = status_zero;
    status_one_next = status_one;
    status_two_next = status_two;
    idle_countdown_next = idle_countdown;
    job = '0;
    job.addr = dma_address[23:0];
    job.spec_t = specify_timing;
    job.spec_l = specify_load;
    job.eot = sectors_per_track;
    job.gap = gap_length;
    unique case (kind)
      fcs_pkg::KIND_RESET, fcs_pkg::KIND_READ, fcs_pkg::KIND_WRITE: begin
        if (phase != fcs_pkg::PH_IDLE) begin
          job.busy = 1'b1;
        end else begin
          wr_op_next = (kind == fcs_pkg::KIND_WRITE);
          attempt_count_next = 5'd0;
          if (kind == fcs_pkg::KIND_RESET) begin
            job.dor_rst = 1'b1;
            motor_mode_next = fcs_pkg::MOTOR_OFF;
            phase_next = fcs_pkg::PH_RST_IRQ;
          end else begin
            target_cylinder_next = cylinder;
            seek_head_next = 1'b0;
            job.motor_on = (motor_mode == fcs_pkg::MOTOR_OFF);
            motor_mode_next = fcs_pkg::MOTOR_ON;
            job.seek = 1'b1;
            job.head = 1'b0;
            job.cyl = cylinder;
            phase_next = fcs_pkg::PH_SEEK_IRQ;
          end
        end
      end
      fcs_pkg::KIND_IRQ: begin
        priority case (phase)
          fcs_pkg::PH_RST_IRQ, fcs_pkg::PH_CAL_IRQ, fcs_pkg::PH_SEEK_IRQ: begin
            job.sense = 1'b1;
            reply_index_next = 3'd0;
            phase_next = fcs_pkg::phase_t'(phase + 4'd1);
          end
          fcs_pkg::PH_XFER_IRQ: begin
            job.xres = 1'b1;
            reply_index_next = 3'd0;
            phase_next = fcs_pkg::PH_XFER_RES;
          end
          default: ;
        endcase
      end
      fcs_pkg::KIND_BYTE: begin
        priority case (phase)
          fcs_pkg::PH_RST_SENSE: begin
            if (reply_index == 3'd0) begin
              reply_index_next = 3'd1;
            end else begin
              job.ccr_spec = 1'b1;
              job.motor_on = (motor_mode == fcs_pkg::MOTOR_OFF);
              motor_mode_next = fcs_pkg::MOTOR_ON;
              attempt_count_next = 5'd0;
              job.recal = 1'b1;
              phase_next = fcs_pkg::PH_CAL_IRQ;
            end
          end
          fcs_pkg::PH_CAL_SENSE, fcs_pkg::PH_SEEK_SENSE: begin
            if (reply_index == 3'd0) begin
              status_zero_next = reply_byte;
              reply_index_next = 3'd1;
            end else if ((status_zero[7:6] == 2'b00) &&
                         (reply_byte == ((phase == fcs_pkg::PH_CAL_SENSE) ?
                                         8'd0 : target_cylinder))) begin
              if (phase == fcs_pkg::PH_CAL_SENSE) begin
                job.done = 1'b1;
                job.status = fcs_pkg::ST_OK;
              end else begin
                attempt_count_next = 5'd0;
                job.cyl = target_cylinder;
                job.wr_op = wr_op;
                if (!seek_head) begin
                  // motor is already on here, so engage rewrites nothing but mode
                  seek_head_next = 1'b1;
                  motor_mode_next = fcs_pkg::MOTOR_ON;
                  job.seek = 1'b1;
                  job.head = 1'b1;
                  phase_next = fcs_pkg::PH_SEEK_IRQ;
                end else if (dma_bad) begin
                  job.done = 1'b1;
                  job.status = fcs_pkg::ST_BADDMA;
                end else begin
                  motor_mode_next = fcs_pkg::MOTOR_ON;
                  job.xfer = 1'b1;
                  phase_next = fcs_pkg::PH_XFER_IRQ;
                end
              end
            end else begin
              attempt_count_next = bumped;
              if (bumped >= seek_retries) begin
                job.done = 1'b1;
                job.status = fcs_pkg::ST_RETRY;
              end else if (phase == fcs_pkg::PH_CAL_SENSE) begin
                job.recal = 1'b1;
                phase_next = fcs_pkg::PH_CAL_IRQ;
              end else begin
                job.seek = 1'b1;
                job.head = seek_head;
                job.cyl = target_cylinder;
                phase_next = fcs_pkg::PH_SEEK_IRQ;
              end
            end
          end
          fcs_pkg::PH_XFER_RES: begin
            if (reply_index == 3'd0) status_zero_next = reply_byte;
            if (reply_index == 3'd1) status_one_next = reply_byte;
            if (reply_index == 3'd2) status_two_next = reply_byte;
            if (reply_index < 3'd6) begin
              reply_index_next = reply_index + 3'd1;
            end else if (status_one[1]) begin
              job.done = 1'b1;
              job.status = fcs_pkg::ST_WPROT;
            end else if (!err) begin
              job.done = 1'b1;
              job.status = fcs_pkg::ST_OK;
            end else begin
              attempt_count_next = bumped;
              if (bumped >= transfer_retries) begin
                job.done = 1'b1;
                job.status = fcs_pkg::ST_RETRY;
              end else begin
                job.motor_on = (motor_mode == fcs_pkg::MOTOR_OFF);
                motor_mode_next = fcs_pkg::MOTOR_ON;
                job.cyl = target_cylinder;
                job.wr_op = wr_op;
                if (dma_bad) begin
                  job.done = 1'b1;
                  job.status = fcs_pkg::ST_BADDMA;
                end else begin
                  job.xfer = 1'b1;
                  phase_next = fcs_pkg::PH_XFER_IRQ;
                end
              end
            end
          end
          default: ;
        endcase
      end
      fcs_pkg::KIND_TICK: begin
        if (motor_mode == fcs_pkg::MOTOR_WAIT) begin
          if (idle_countdown <= 4'd1) begin
            idle_countdown_next = 4'd0;
            job.dor_off = 1'b1;
            motor_mode_next = fcs_pkg::MOTOR_OFF;
          end else begin
            idle_countdown_next = idle_countdown - 4'd1;
          end
        end
      end
      default: ;
    endcase
    // an operation that ends leaves the motor waiting
    if (job.done) begin
      motor_mode_next = fcs_pkg::MOTOR_WAIT;
      idle_countdown_next = motor_idle_ticks;
      phase_next = fcs_pkg::PH_IDLE;
    end else if (kind == fcs_pkg::KIND_BYTE && phase == fcs_pkg::PH_SEEK_SENSE &&
                 reply_index != 3'd0 && phase_next != fcs_pkg::PH_SEEK_SENSE &&
                 attempt_count_next == 5'd0) begin
      idle_countdown_next = motor_idle_ticks;
    end
  end

  assign push = in_valid && in_ready;

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fcs_pkg::PH_IDLE;
      motor_mode <= fcs_pkg::MOTOR_OFF;
      wr_op <= 1'b0;
      attempt_count <= '0;
      target_cylinder <= '0;
      seek_head <= 1'b0;
      reply_index <= '0;
      status_zero <= '0;
      status_one <= '0;
      status_two <= '0;
      idle_countdown <= '0;
    end else if (push) begin
      phase <= phase_next;
      motor_mode <= motor_mode_next;
      wr_op <= wr_op_next;
      attempt_count <= attempt_count_next;
      target_cylinder <= target_cylinder_next;
      seek_head <= seek_head_next;
      reply_index <= reply_index_next;
      status_zero <= status_zero_next;
      status_one <= status_one_next;
      status_two <= status_two_next;
      idle_countdown <= idle_countdown_next;
    end
  end

  // the reply index never goes beyond the last of the seven result bytes
  assert property (@(posedge clk) disable iff (rst) reply_index <= 3'd6)
    else $error("reply index out of range");
  // a done job always returns the phase to idle
  assert property (@(posedge clk) disable iff (rst) push && job.done |=>
                   phase == fcs_pkg::PH_IDLE)
    else $error("phase not idle after done");
  // busy refusal changes no phase
  assert property (@(posedge clk) disable iff (rst) push && job.busy |=>
                   phase == $past(phase))
    else $error("busy refusal changed phase");
endmodule
`default_nettype wire

FILE: hdl/fcs_back.sv
// ---------------------------------------------------------------------------
// fcs_back: job emitter
// Walks the result slots of one job, one result per cycle unless the output
// stalls, into a skid-free output register; the last emitted slot carries tlast.
// ---------------------------------------------------------------------------
`default_nettype none
module fcs_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  output logic             job_take,
  input  fcs_pkg::job_t    job,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       action,
  output logic [9:0]       port,
  output logic [7:0]       value,
  output logic [2:0]       status,
  output logic             last
);
  // slot numbering over the full result list of a job
  localparam int NSLOT = 42;
  logic [5:0] slot, slot_next;
  logic       en;
  logic [1:0] s_act;
  logic [9:0] s_port;
  logic [7:0] s_val;
  logic [2:0] s_st;
  logic [5:0] nxt;
  logic       more;
  logic       load;

  // is slot s part of this job
  function automatic logic slot_en(input fcs_pkg::job_t j, input logic [5:0] s);
    logic r;
    r = 1'b0;
    if (s == 6'd0) r = j.busy;
    else if (s <= 6'd2) r = j.dor_rst;
    else if (s <= 6'd5) r = j.sense;
    else if (s <= 6'd12) r = j.xres;
    else if (s <= 6'd16) r = j.ccr_spec;
    else if (s == 6'd17) r = j.motor_on;
    else if (s <= 6'd19) r = j.recal;
    else if (s <= 6'd22) r = j.seek;
    else if (s <= 6'd41) r = j.xfer;
    else if (s == 6'd42) r = j.dor_off;
    else r = j.done;
    return r;
  endfunction

  logic [NSLOT+1:0] mask;
  always_comb begin
    for (int i = 0; i < NSLOT + 2; i++) mask[i] = slot_en(job, 6'(i));
  end

  // first enabled slot at or after slot+1
  always_comb begin
    nxt = 6'd0;
    more = 1'b0;
    for (int i = NSLOT + 1; i >= 0; i--) begin
      if (mask[i] && 6'(i) > slot) begin
        nxt = 6'(i);
        more = 1'b1;
      end
    end
  end

  // slot contents
  always_comb begin
    s_act = fcs_pkg::ACT_WRITE;
    s_port = fcs_pkg::PORT_FIFO;
    s_val = 8'd0;
    s_st = 3'd0;
    unique case (slot)
      6'd0: begin s_act = fcs_pkg::ACT_DONE; s_port = '0; s_st = fcs_pkg::ST_BUSY; end
      6'd1: begin s_port = fcs_pkg::PORT_DOR; s_val = 8'h00; end
      6'd2: begin s_port = fcs_pkg::PORT_DOR; s_val = 8'h0c; end
      6'd3: s_val = 8'h08;
      6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12: s_act = fcs_pkg::ACT_READ;
      6'd13: begin s_port = fcs_pkg::PORT_CCR; s_val = 8'h00; end
      6'd14: s_val = 8'h03;
      6'd15: s_val = job.spec_t;
      6'd16: s_val = job.spec_l;
      6'd17: begin s_port = fcs_pkg::PORT_DOR; s_val = 8'h1c; end
      6'd18: s_val = 8'h07;
      6'd19: s_val = 8'h00;
      6'd20: s_val = 8'h0f;
      6'd21: s_val = {5'd0, job.head, 2'd0};
      6'd22: s_val = job.cyl;
      6'd23: begin s_port = 10'h00a; s_val = 8'h06; end
      6'd24: begin s_port = 10'h00c; s_val = 8'hff; end
      6'd25: begin s_port = 10'h004; s_val = job.addr[7:0]; end
      6'd26: begin s_port = 10'h004; s_val = job.addr[15:8]; end
      6'd27: begin s_port = 10'h081; s_val = job.addr[23:16]; end
      6'd28: begin s_port = 10'h00c; s_val = 8'hff; end
      6'd29: begin s_port = 10'h005; s_val = fcs_pkg::XFER_LAST[7:0]; end
      6'd30: begin s_port = 10'h005; s_val = fcs_pkg::XFER_LAST[15:8]; end
      6'd31: begin s_port = 10'h00b; s_val = job.wr_op ? 8'h4a : 8'h46; end
      6'd32: begin s_port = 10'h00a; s_val = 8'h02; end
      6'd33: s_val = job.wr_op ? 8'hc5 : 8'hc6;
      6'd34: s_val = 8'h00;
      6'd35: s_val = job.cyl;
      6'd36: s_val = 8'h00;
      6'd37: s_val = 8'h01;
      6'd38: s_val = 8'h02;
      6'd39: s_val = job.eot;
      6'd40: s_val = job.gap;
      6'd41: s_val = 8'hff;
      6'd42: begin s_port = fcs_pkg::PORT_DOR; s_val = 8'h0c; end
      6'd43: begin s_act = fcs_pkg::ACT_DONE; s_port = '0; s_st = job.status; end
      default: ;
    endcase
  end

  assign en = job_valid && mask[slot];
  assign load = !out_valid || out_ready;

  // walk slots; a job with no slots is dropped at once
  always_comb begin
    job_take = 1'b0;
    slot_next = slot;
    if (job_valid && (load || !en)) begin
      if (more) slot_next = nxt;
      else begin
        slot_next = 6'd0;
        job_take = 1'b1;
      end
    end
    if (job_valid && !en && slot == 6'd0 && !more) job_take = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      out_valid <= 1'b0;
    end else begin
      slot <= slot_next;
      if (load) out_valid <= en;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load && en) begin
      action <= s_act;
      port <= s_port;
      value <= s_val;
      status <= s_st;
      last <= !more;
    end
  end

  // after a job is released the slot walk is back at slot 0
  assert property (@(posedge clk) disable iff (rst) job_take |=> slot == 6'd0)
    else $error("slot not rewound");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=>
                   out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) !job_valid |=> slot == $past(slot))
    else $error("slot moved without job");
endmodule
`default_nettype wire
